### design/alsbc_pkg.sv
// ----------------------------------------------------------------------------
// alsbc_pkg: shared definitions for the alarm level sequencer
// Level codes, event codes, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package alsbc_pkg;

  typedef logic [1:0] level_t;
  typedef logic [2:0] action_t;
  typedef logic [2:0] cfg_index_t;

  localparam level_t LVL_SAFE = 2'd0;
  localparam level_t LVL_WARN = 2'd1;
  localparam level_t LVL_FULL = 2'd2;

  localparam action_t ACT_TICK    = 3'd0;
  localparam action_t ACT_WARN    = 3'd1;
  localparam action_t ACT_FULL    = 3'd2;
  localparam action_t ACT_RETURN  = 3'd3;
  localparam action_t ACT_FORCE   = 3'd4;
  localparam action_t ACT_SILENCE = 3'd5;

  localparam cfg_index_t REG_ALARM_ON    = 3'd0;
  localparam cfg_index_t REG_ALARM_OFF   = 3'd1;
  localparam cfg_index_t REG_WARNING_ON  = 3'd2;
  localparam cfg_index_t REG_WARNING_OFF = 3'd3;
  localparam cfg_index_t REG_SAFE_DELAY  = 3'd4;

  localparam logic [15:0] ALARM_ON_RESET    = 16'd200;
  localparam logic [15:0] ALARM_OFF_RESET   = 16'd200;
  localparam logic [15:0] WARNING_ON_RESET  = 16'd100;
  localparam logic [15:0] WARNING_OFF_RESET = 16'd900;
  localparam logic [31:0] SAFE_DELAY_RESET  = 32'd10000;

endpackage

### design/alarm_level_sequencer_with_beep_cadence.sv
// ----------------------------------------------------------------------------
// alarm_level_sequencer_with_beep_cadence
// Three-level alarm controller with a per-level buzzer on/off cadence.
// ----------------------------------------------------------------------------
// Each input transaction carries one event: a millisecond tick, a warning or
// full-alarm trigger, a return-to-safe request, a forced safe, or a silence
// with its duration in silence_ms. Every event produces exactly one output
// transaction that reports the current level, the pending target level, the
// three LEDs, the relay drive and the buzzer drive after that event.
// The configuration port (cfg_we, cfg_index, cfg_data) sets the buzzer on and
// off times of both alarm levels and the safe delay; writes take effect at
// once and must only be issued while the block is idle.
// Both channels use valid/ready. An accepted event sits in an input register
// until the output register is free or being emptied, and is then applied to
// the state while its result is loaded into the output register. Throughput
// is one event per cycle unless the receiver stalls; it is set by the state
// update (32-bit increment, subtract and compare) between the two registers.
// When the receiver stalls, the output register holds its transaction and the
// input register fills; in_ready drops only once both are occupied.
// Reset (rst, synchronous) returns both levels to safe, clears the clock,
// the clear timer, the buzzer and the mute, and loads the default register
// values.
// ----------------------------------------------------------------------------
module alarm_level_sequencer_with_beep_cadence (
  input  logic                    clk,
  input  logic                    rst,
  // Configuration write port
  input  logic                    cfg_we,
  input  alsbc_pkg::cfg_index_t   cfg_index,
  input  logic [31:0]             cfg_data,
  // Event channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  alsbc_pkg::action_t      action,
  input  logic [31:0]             silence_ms,
  // Result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output alsbc_pkg::level_t       level,
  output alsbc_pkg::level_t       pending_level,
  output logic                    green_led,
  output logic                    yellow_led,
  output logic                    red_led,
  output logic                    relay_drive,
  output logic                    buzzer_drive
);
  import alsbc_pkg::*;

  // Configuration registers.
  logic [15:0] alarm_on_ms;
  logic [15:0] alarm_off_ms;
  logic [15:0] warning_on_ms;
  logic [15:0] warning_off_ms;
  logic [31:0] clear_delay_ms;

  // Block state.
  logic [31:0] time_now;
  level_t      target_level;
  level_t      current_level;
  logic        clear_pending;
  logic [31:0] clear_start_time;
  logic [31:0] last_toggle_time;
  logic        tone_active;
  logic [31:0] mute_until;

  // Input register holding one accepted event.
  logic        s1_valid;
  action_t     s1_action;
  logic [31:0] s1_silence_ms;

  // The input register advances whenever the output register is free or
  // being emptied in this cycle.
  logic s1_advance;
  assign s1_advance = !out_valid || out_ready;
  assign in_ready   = !s1_valid || s1_advance;

  logic apply;
  assign apply = s1_valid && s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_on_ms    <= ALARM_ON_RESET;
      alarm_off_ms   <= ALARM_OFF_RESET;
      warning_on_ms  <= WARNING_ON_RESET;
      warning_off_ms <= WARNING_OFF_RESET;
      clear_delay_ms <= SAFE_DELAY_RESET;
    end else if (cfg_we) begin
      // Indexes beyond the register list are ignored.
      unique case (cfg_index)
        REG_ALARM_ON:    alarm_on_ms    <= cfg_data[15:0];
        REG_ALARM_OFF:   alarm_off_ms   <= cfg_data[15:0];
        REG_WARNING_ON:  warning_on_ms  <= cfg_data[15:0];
        REG_WARNING_OFF: warning_off_ms <= cfg_data[15:0];
        REG_SAFE_DELAY:  clear_delay_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_action     <= action;
      s1_silence_ms <= silence_ms;
    end
  end

  // --------------------------------------------------------------------------
  // Next-state logic for the event in the input register.
  // --------------------------------------------------------------------------
  logic [31:0] time_now_next;
  level_t      target_level_next;
  level_t      current_level_next;
  logic        clear_pending_next;
  logic [31:0] clear_start_time_next;
  logic [31:0] last_toggle_time_next;
  logic        tone_active_next;
  logic [31:0] mute_until_next;

  // Tick path: time advances first, then the buzzer is judged at the new time.
  logic [31:0] tick_time;
  logic [31:0] tick_elapsed;
  logic [31:0] on_time;
  logic [31:0] off_time;
  logic        tick_muted;
  assign tick_time    = time_now + 32'd1;
  assign tick_elapsed = tick_time - last_toggle_time;
  assign tick_muted   = mute_until > tick_time;
  assign on_time  = {16'd0, (target_level == LVL_FULL) ? alarm_on_ms  : warning_on_ms};
  assign off_time = {16'd0, (target_level == LVL_FULL) ? alarm_off_ms : warning_off_ms};

  // Return path: a clear that starts now has zero elapsed time.
  logic [31:0] clear_elapsed;
  logic        clear_armed;
  assign clear_elapsed = clear_pending ? (time_now - clear_start_time) : 32'd0;
  assign clear_armed   = clear_pending || (target_level != LVL_SAFE);

  always_comb begin
    time_now_next         = time_now;
    target_level_next     = target_level;
    current_level_next    = current_level;
    clear_pending_next    = clear_pending;
    clear_start_time_next = clear_start_time;
    last_toggle_time_next = last_toggle_time;
    tone_active_next      = tone_active;
    mute_until_next       = mute_until;
    unique case (s1_action)
      ACT_TICK: begin
        time_now_next      = tick_time;
        current_level_next = target_level;
        if (tick_muted || target_level == LVL_SAFE) begin
          tone_active_next = 1'b0;
        end else if (tone_active) begin
          if (tick_elapsed >= on_time) begin
            tone_active_next      = 1'b0;
            last_toggle_time_next = tick_time;
          end
        end else if (tick_elapsed >= off_time) begin
          tone_active_next      = 1'b1;
          last_toggle_time_next = tick_time;
        end
      end
      ACT_WARN: begin
        target_level_next  = LVL_WARN;
        clear_pending_next = 1'b0;
      end
      ACT_FULL: begin
        target_level_next  = LVL_FULL;
        clear_pending_next = 1'b0;
      end
      ACT_RETURN: begin
        if (!clear_pending && target_level != LVL_SAFE) begin
          clear_pending_next    = 1'b1;
          clear_start_time_next = time_now;
        end
        if (clear_armed && clear_elapsed >= clear_delay_ms) begin
          target_level_next  = LVL_SAFE;
          clear_pending_next = 1'b0;
        end
      end
      ACT_FORCE: begin
        target_level_next  = LVL_SAFE;
        clear_pending_next = 1'b0;
      end
      ACT_SILENCE: begin
        mute_until_next  = time_now + s1_silence_ms;
        tone_active_next = 1'b0;
      end
      // Unused event codes leave the state untouched.
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now         <= 32'd0;
      target_level     <= LVL_SAFE;
      current_level    <= LVL_SAFE;
      clear_pending    <= 1'b0;
      clear_start_time <= 32'd0;
      last_toggle_time <= 32'd0;
      tone_active      <= 1'b0;
      mute_until       <= 32'd0;
    end else if (apply) begin
      time_now         <= time_now_next;
      target_level     <= target_level_next;
      current_level    <= current_level_next;
      clear_pending    <= clear_pending_next;
      clear_start_time <= clear_start_time_next;
      last_toggle_time <= last_toggle_time_next;
      tone_active      <= tone_active_next;
      mute_until       <= mute_until_next;
    end
  end

  // --------------------------------------------------------------------------
  // Output register, loaded with the state after the applied event.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      level         <= current_level_next;
      pending_level <= target_level_next;
      green_led     <= (current_level_next == LVL_SAFE);
      yellow_led    <= (current_level_next == LVL_WARN);
      red_led       <= (current_level_next == LVL_FULL);
      relay_drive   <= (current_level_next != LVL_FULL);
      buzzer_drive  <= tone_active_next;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Exactly one LED is lit in every delivered result.
  a_one_led: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot({green_led, yellow_led, red_led}))
    else $error("LED outputs are not one-hot");

  // The relay drops exactly when the red LED is lit.
  a_relay_red: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (relay_drive != red_led))
    else $error("relay drive disagrees with full alarm level");

  // The buzzer never sounds while the current level is safe.
  a_quiet_safe: assert property (@(posedge clk) disable iff (rst)
    (current_level == LVL_SAFE) |-> !tone_active)
    else $error("buzzer active at safe level");

  // The state moves only when an event is applied.
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(apply) && !$past(rst) |-> $stable(time_now) && $stable(target_level))
    else $error("state changed without an applied event");

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the alarm level sequencer
// Drives event transactions over valid/ready, mirrors the alarm state in a
// local predictor and checks every result transaction, field by field, in
// order. A short scripted sequence comes first, then randomized phases
// under several register settings with bursty input and a stalling sink.
// ----------------------------------------------------------------------------
module tb;
  import alsbc_pkg::*;

  // Event codes and register indexes that the package leaves unnamed. The
  // block must accept these and leave its state alone.
  localparam action_t    ACT_SPARE6 = 3'd6;
  localparam action_t    ACT_SPARE7 = 3'd7;
  localparam cfg_index_t REG_SPARE5 = 3'd5;
  localparam cfg_index_t REG_SPARE7 = 3'd7;

  localparam int PHASES        = 6;
  localparam int PHASE_EVENTS  = 175;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 8;
  // About 1150 transactions, each at worst behind a sender gap and a sparse
  // sink (one ready in four), plus holds and drains. The limit leaves a wide
  // margin on top of that.
  localparam int LIMIT_CYCLES  = 200000;

  typedef struct packed {
    level_t level;
    level_t pending;
    logic   green;
    logic   yellow;
    logic   red;
    logic   relay;
    logic   buzzer;
  } report_t;

  typedef struct {
    logic        is_write;
    logic [2:0]  code;
    logic [31:0] data;
    logic        typed;
    report_t     want;
  } script_row_t;

  typedef enum {SINK_FLOW, SINK_COIN, SINK_SPARSE, SINK_TOGGLE} sink_mode_t;

  // Every input of the block starts at a known value.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  cfg_index_t  cfg_index = REG_ALARM_ON;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  action_t     action = ACT_TICK;
  logic [31:0] silence_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  level_t      level;
  level_t      pending_level;
  logic        green_led;
  logic        yellow_led;
  logic        red_led;
  logic        relay_drive;
  logic        buzzer_drive;

  // A scripted row may carry a hand-written result; it rides along with the
  // event transaction so that the monitor picks it up at acceptance.
  logic        item_typed = 1'b0;
  report_t     item_want = '0;

  // Local copy of the register file, loaded with the reset values.
  logic [15:0] alm_on  = ALARM_ON_RESET;
  logic [15:0] alm_off = ALARM_OFF_RESET;
  logic [15:0] wrn_on  = WARNING_ON_RESET;
  logic [15:0] wrn_off = WARNING_OFF_RESET;
  logic [31:0] hold_ms = SAFE_DELAY_RESET;

  // Local copy of the alarm state; everything clears to zero (safe).
  logic [31:0] ms_now      = '0;
  level_t      tgt_lvl     = LVL_SAFE;
  level_t      cur_lvl     = LVL_SAFE;
  logic        clr_armed   = 1'b0;
  logic [31:0] clr_start   = '0;
  logic [31:0] toggle_at   = '0;
  logic        tone_on     = 1'b0;
  logic [31:0] quiet_until = '0;

  report_t     due_reports[$];
  script_row_t script[$];
  report_t     predicted;
  report_t     seen;
  report_t     wanted;
  int          mismatches  = 0;
  int          events_sent = 0;
  int          cycles      = 0;

  // Sender burst control and sink stall control.
  int          burst_left  = 0;
  bit          steady      = 1'b0;
  bit          want_hold   = 1'b0;
  int          hold_left   = 0;
  sink_mode_t  sink_mode   = SINK_FLOW;
  int          sink_left   = 0;

  alarm_level_sequencer_with_beep_cadence i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .silence_ms    (silence_ms),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .level         (level),
    .pending_level (pending_level),
    .green_led     (green_led),
    .yellow_led    (yellow_led),
    .red_led       (red_led),
    .relay_drive   (relay_drive),
    .buzzer_drive  (buzzer_drive)
  );

  always #6 clk = ~clk;

  // The LEDs and the relay are pure decodes of the current level.
  function automatic report_t mk_report(level_t lvl, level_t pend, logic buzz);
    report_t r;
    r.level   = lvl;
    r.pending = pend;
    r.green   = (lvl == LVL_SAFE);
    r.yellow  = (lvl == LVL_WARN);
    r.red     = (lvl == LVL_FULL);
    r.relay   = (lvl != LVL_FULL);
    r.buzzer  = buzz;
    return r;
  endfunction

  // Applies one event to the local alarm state and returns the report that
  // the block must produce for it.
  function automatic report_t advance_alarm(action_t act, logic [31:0] quiet_ms);
    logic [31:0] on_ms;
    logic [31:0] off_ms;
    logic [31:0] since;
    case (act)
      ACT_TICK: begin
        // The clock moves first, then the level follows the target, and the
        // buzzer is judged at the new time.
        ms_now  = ms_now + 32'd1;
        cur_lvl = tgt_lvl;
        if (quiet_until > ms_now || cur_lvl == LVL_SAFE) begin
          // Muted or safe: the tone stops but the toggle time is kept.
          tone_on = 1'b0;
        end else begin
          on_ms  = (cur_lvl == LVL_FULL) ? {16'd0, alm_on} : {16'd0, wrn_on};
          off_ms = (cur_lvl == LVL_FULL) ? {16'd0, alm_off} : {16'd0, wrn_off};
          since  = ms_now - toggle_at;
          if (tone_on) begin
            if (since >= on_ms) begin
              tone_on   = 1'b0;
              toggle_at = ms_now;
            end
          end else if (since >= off_ms) begin
            tone_on   = 1'b1;
            toggle_at = ms_now;
          end
        end
      end
      ACT_WARN: begin
        tgt_lvl   = LVL_WARN;
        clr_armed = 1'b0;
      end
      ACT_FULL: begin
        tgt_lvl   = LVL_FULL;
        clr_armed = 1'b0;
      end
      ACT_RETURN: begin
        // The first request only starts the clear timer; a zero delay lets
        // the same request finish the clear as well.
        if (tgt_lvl != LVL_SAFE && !clr_armed) begin
          clr_armed = 1'b1;
          clr_start = ms_now;
        end
        if (clr_armed && (ms_now - clr_start) >= hold_ms) begin
          tgt_lvl   = LVL_SAFE;
          clr_armed = 1'b0;
        end
      end
      ACT_FORCE: begin
        tgt_lvl   = LVL_SAFE;
        clr_armed = 1'b0;
      end
      ACT_SILENCE: begin
        // The mute end wraps modulo 2^32 and is then compared unsigned.
        quiet_until = ms_now + quiet_ms;
        tone_on     = 1'b0;
      end
      default: begin
      end
    endcase
    return mk_report(cur_lvl, tgt_lvl, tone_on);
  endfunction

  function automatic string show(report_t r);
    return $sformatf("level=%0d pending=%0d g/y/r=%b%b%b relay=%b buzzer=%b",
                     r.level, r.pending, r.green, r.yellow, r.red, r.relay, r.buzzer);
  endfunction

  // Mute lengths: mostly short, some that wrap past the end of the clock.
  function automatic logic [31:0] quiet_span();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'hFFFF_FFFF - $urandom_range(0, 20);
      default: return $urandom_range(0, 25);
    endcase
  endfunction

  // A 16-bit register value with random bits above it, which the block
  // must drop.
  function automatic logic [31:0] with_junk(logic [15:0] v);
    logic [31:0] j;
    j = $urandom;
    return {j[31:16], v};
  endfunction

  task automatic plan(logic is_write, logic [2:0] code, logic [31:0] data,
                      logic typed = 1'b0, report_t want = '0);
    script.push_back('{is_write, code, data, typed, want});
  endtask

  // Offers one event transaction and returns once it has been accepted.
  // Between bursts the sender may drop valid for a random gap, unless steady.
  task automatic send_event(action_t act, logic [31:0] dur,
                            logic typed = 1'b0, report_t want = '0);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady && $urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    action     <= act;
    silence_ms <= dur;
    item_typed <= typed;
    item_want  <= want;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    events_sent++;
  endtask

  // Stops offering and waits until every expected result has come back,
  // then lets the two-stage pipeline settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_reports.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  // Register writes happen only with the block idle, so the local copy can
  // be updated right away.
  task automatic write_reg(cfg_index_t idx, logic [31:0] val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_ALARM_ON:    alm_on  = val[15:0];
      REG_ALARM_OFF:   alm_off = val[15:0];
      REG_WARNING_ON:  wrn_on  = val[15:0];
      REG_WARNING_OFF: wrn_off = val[15:0];
      REG_SAFE_DELAY:  hold_ms = val;
      default: begin
      end
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sink: holds off for a long stretch on request, otherwise walks through
  // stall patterns of random length, from always ready to one in four.
  always @(posedge clk) begin
    if (want_hold) begin
      want_hold = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (sink_left == 0) begin
        sink_mode = sink_mode_t'($urandom_range(0, 3));
        sink_left = $urandom_range(8, 60);
      end
      sink_left--;
      case (sink_mode)
        SINK_FLOW:   out_ready <= 1'b1;
        SINK_COIN:   out_ready <= 1'($urandom_range(0, 1));
        SINK_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:     out_ready <= ~out_ready;
      endcase
    end
  end

  // Monitor: every accepted event transaction queues one expected report,
  // every accepted result transaction is compared with the oldest one.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        predicted = advance_alarm(action, silence_ms);
        due_reports.push_back(item_typed ? item_want : predicted);
      end
      if (out_valid && out_ready) begin
        seen = {level, pending_level, green_led, yellow_led, red_led,
                relay_drive, buzzer_drive};
        if (due_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("cycle %0d: result with nothing expected: %s", cycles, show(seen));
        end else begin
          wanted = due_reports.pop_front();
          if (seen !== wanted) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("cycle %0d: result mismatch", cycles);
              $display("  expected %s", show(wanted));
              $display("  actual   %s", show(seen));
            end
          end
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int      goal;
    int      mid;
    bit      paused;
    action_t pick;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Scripted part. Results that are plain to see are written out by hand;
    // the rest come from the predictor.
    // Out of reset, with nothing triggered, everything reports safe: a tick,
    // the two unused codes, a return request with nothing to clear, and a
    // silence whose end wraps around.
    plan(1'b0, ACT_TICK, 32'd0, 1'b1, mk_report(LVL_SAFE, LVL_SAFE, 1'b0));
    plan(1'b0, ACT_SPARE6, 32'hFFFF_FFFF, 1'b1, mk_report(LVL_SAFE, LVL_SAFE, 1'b0));
    plan(1'b0, ACT_SPARE7, 32'd0, 1'b1, mk_report(LVL_SAFE, LVL_SAFE, 1'b0));
    plan(1'b0, ACT_RETURN, 32'd0, 1'b1, mk_report(LVL_SAFE, LVL_SAFE, 1'b0));
    plan(1'b0, ACT_SILENCE, 32'hFFFF_FFFF, 1'b1, mk_report(LVL_SAFE, LVL_SAFE, 1'b0));
    // Short cadences and delay so the buzzer and the clear timer move within
    // a few ticks. The alarm on time carries junk in its upper half, and the
    // unused indexes must be ignored.
    plan(1'b1, REG_ALARM_ON, 32'hFFFF_0001);
    plan(1'b1, REG_ALARM_OFF, 32'd0);
    plan(1'b1, REG_WARNING_ON, 32'd2);
    plan(1'b1, REG_WARNING_OFF, 32'd1);
    plan(1'b1, REG_SAFE_DELAY, 32'd3);
    plan(1'b1, REG_SPARE5, 32'hFFFF_FFFF);
    plan(1'b1, REG_SPARE7, 32'd0);
    // A trigger only moves the target until the next tick.
    plan(1'b0, ACT_FULL, 32'd0, 1'b1, mk_report(LVL_SAFE, LVL_FULL, 1'b0));
    plan(1'b0, ACT_TICK, 32'd0);
    plan(1'b0, ACT_TICK, 32'd0);
    // Return requests: the first arms the timer, later ones clear once the
    // delay has passed.
    plan(1'b0, ACT_RETURN, 32'd0);
    plan(1'b0, ACT_TICK, 32'd0);
    plan(1'b0, ACT_RETURN, 32'd0);
    plan(1'b0, ACT_TICK, 32'd0);
    plan(1'b0, ACT_TICK, 32'd0);
    plan(1'b0, ACT_RETURN, 32'd0);
    // Warning cadence, a wrapping silence that does not mute, then a short
    // mute that runs out.
    plan(1'b0, ACT_WARN, 32'd0);
    plan(1'b0, ACT_TICK, 32'd0);
    plan(1'b0, ACT_SILENCE, 32'hFFFF_FFFF);
    plan(1'b0, ACT_TICK, 32'd0);
    plan(1'b0, ACT_SILENCE, 32'd2);
    plan(1'b0, ACT_TICK, 32'd0);
    plan(1'b0, ACT_TICK, 32'd0);
    // Forcing safe silences the buzzer at the next tick.
    plan(1'b0, ACT_FORCE, 32'd0);
    plan(1'b0, ACT_TICK, 32'd0, 1'b1, mk_report(LVL_SAFE, LVL_SAFE, 1'b0));
    // With a zero delay one request both arms and completes the clear.
    plan(1'b1, REG_SAFE_DELAY, 32'd0);
    plan(1'b0, ACT_FULL, 32'd0, 1'b1, mk_report(LVL_SAFE, LVL_FULL, 1'b0));
    plan(1'b0, ACT_RETURN, 32'd0, 1'b1, mk_report(LVL_SAFE, LVL_SAFE, 1'b0));

    foreach (script[i]) begin
      if (script[i].is_write) begin
        write_reg(script[i].code, script[i].data);
      end else begin
        send_event(script[i].code, script[i].data, script[i].typed, script[i].want);
      end
    end

    // Random phases, each under its own register setting.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        1: begin
          // Upper extremes on the alarm on time and the delay: once on, the
          // full-alarm tone never stops, and nothing ever clears.
          write_reg(REG_ALARM_ON, 32'd65535);
          write_reg(REG_ALARM_OFF, 32'd0);
          write_reg(REG_WARNING_ON, 32'd0);
          write_reg(REG_WARNING_OFF, 32'd65535);
          write_reg(REG_SAFE_DELAY, 32'hFFFF_FFFF);
        end
        2: begin
          // All zero: the tone flips on every unmuted alarm tick and clears are immediate.
          write_reg(REG_ALARM_ON, 32'd0);
          write_reg(REG_ALARM_OFF, 32'd0);
          write_reg(REG_WARNING_ON, 32'd0);
          write_reg(REG_WARNING_OFF, 32'd0);
          write_reg(REG_SAFE_DELAY, 32'd0);
        end
        3: begin
          write_reg(REG_ALARM_ON, 32'd0);
          write_reg(REG_ALARM_OFF, 32'd65535);
          write_reg(REG_WARNING_ON, 32'd65535);
          write_reg(REG_WARNING_OFF, 32'd0);
          write_reg(REG_SAFE_DELAY, 32'd1);
        end
        default: begin
          write_reg(REG_ALARM_ON, with_junk(16'($urandom_range(0, 6))));
          write_reg(REG_ALARM_OFF, with_junk(16'($urandom_range(0, 6))));
          write_reg(REG_WARNING_ON, with_junk(16'($urandom_range(0, 6))));
          write_reg(REG_WARNING_OFF, with_junk(16'($urandom_range(0, 8))));
          write_reg(REG_SAFE_DELAY, $urandom_range(0, 12));
        end
      endcase
      write_reg(cfg_index_t'($urandom_range(REG_SPARE5, REG_SPARE7)), $urandom);

      goal   = events_sent + PHASE_EVENTS;
      mid    = events_sent + PHASE_EVENTS / 2;
      paused = 1'b0;
      if (p == 4) begin
        // Back pressure: the sink holds off while the sender keeps offering
        // without gaps, so the pipeline fills and in_ready drops.
        want_hold = 1'b1;
        steady    = 1'b1;
      end

      while (events_sent < goal) begin
        if (p == 4 && events_sent >= mid)
          steady = 1'b0;
        if (p == 5 && !paused && events_sent >= mid) begin
          // The sender waits here until every result is back.
          wait_drained();
          paused = 1'b1;
        end
        if ($urandom_range(0, 9) < 7) begin
          // A hazard episode: a trigger, time passing, perhaps a silence, and
          // a run of return requests spread over ticks.
          send_event($urandom_range(0, 1) ? ACT_WARN : ACT_FULL, $urandom);
          repeat ($urandom_range(1, 12)) send_event(ACT_TICK, $urandom);
          if ($urandom_range(0, 3) == 0)
            send_event(ACT_SILENCE, quiet_span());
          repeat ($urandom_range(1, 6)) begin
            send_event(ACT_RETURN, $urandom);
            repeat ($urandom_range(0, 6)) send_event(ACT_TICK, $urandom);
          end
        end else begin
          // Noise: any code at all, in any order.
          pick = action_t'($urandom_range(0, 7));
          send_event(pick, (pick == ACT_SILENCE) ? quiet_span() : $urandom);
        end
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (due_reports.size() != 0)
      $display("%0d expected result transactions never arrived", due_reports.size());
    if (mismatches == 0 && due_reports.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
